### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define AST_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define AST_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ncrs_pkg.sv
// ---------------------------------------------------------------------------
// ncrs_pkg
// Widths, limits and pipeline types of the nonuniform Catmull-Rom segment.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ncrs_pkg;

  // Payload widths
  localparam int PT_W  = 32;
  localparam int IV_W  = 31;
  localparam int PS_W  = 17;

  // Internal widths
  localparam int ACC_W = 48;   // coefficient and Horner accumulators
  localparam int PRD_W = 64;   // exact |diff| * dt1 product
  localparam int DVS_W = 32;   // divisor (interval or interval sum)
  localparam int QUO_W = 41;   // quotient bits kept, 2^40 saturation point
  localparam int TRM_W = 42;   // signed ratio term

  // One in Q1.16 and its fraction bit count
  localparam logic [PS_W-1:0] S_ONE = 17'h10000;
  localparam int              S_FRAC = 16;

  // Ratio and tangent limit 2^40
  localparam logic [QUO_W-1:0]        QUO_LIM = 41'h100_0000_0000;
  localparam logic signed [ACC_W-1:0] TAN_LIM = 48'sh0100_0000_0000;

  // Signed 32-bit bounds in accumulator width
  localparam logic signed [ACC_W-1:0] POS_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] NEG_MIN = 48'shFFFF_8000_0000;

  // Ratio lanes
  localparam int NLANE = 4;

  // One divider lane in flight
  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] low;
    logic [DVS_W-1:0] dvs;
    logic             ovf;
    logic             neg;
  } div_lane_t;

  // Product lane after the multiplier
  typedef struct packed {
    logic [PRD_W-1:0] prod;
    logic [DVS_W-1:0] dvs;
    logic             neg;
  } mul_lane_t;

  // Data riding beside the divider lanes
  typedef struct packed {
    logic signed [PT_W-1:0] pb;
    logic signed [PT_W-1:0] pc;
    logic [PS_W-1:0]        s;
    logic                   bad;
  } side_t;

endpackage

`default_nettype wire

### rtl/ncrs_if.sv
// ---------------------------------------------------------------------------
// ncrs_in_if / ncrs_out_if
// Valid/ready channels for segment samples and their results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ncrs_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ncrs_pkg::PT_W-1:0]   point_a;
  logic signed [ncrs_pkg::PT_W-1:0]   point_b;
  logic signed [ncrs_pkg::PT_W-1:0]   point_c;
  logic signed [ncrs_pkg::PT_W-1:0]   point_d;
  logic [ncrs_pkg::IV_W-1:0]          interval_first;
  logic [ncrs_pkg::IV_W-1:0]          interval_middle;
  logic [ncrs_pkg::IV_W-1:0]          interval_last;
  logic [ncrs_pkg::PS_W-1:0]          param_s;

  modport source (output valid, point_a, point_b, point_c, point_d,
                  interval_first, interval_middle, interval_last, param_s,
                  input ready);
  modport sink   (input valid, point_a, point_b, point_c, point_d,
                  interval_first, interval_middle, interval_last, param_s,
                  output ready);
endinterface

interface ncrs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ncrs_pkg::PT_W-1:0]   position;
  logic signed [ncrs_pkg::PT_W-1:0]   tangent;
  logic                               bad_interval;

  modport source (output valid, position, tangent, bad_interval, input ready);
  modport sink   (input valid, position, tangent, bad_interval, output ready);
endinterface

`default_nettype wire

### rtl/nonuniform_catmull_rom_segment.sv
// ---------------------------------------------------------------------------
// nonuniform_catmull_rom_segment
// Evaluates one axis of a nonuniform Catmull-Rom segment: position and
// tangent of the Hermite cubic at s, Q16.16 in and out, saturated.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | point_a..d, interval_*, param_s
//  out_ch  | out | valid / ready | position, tangent, bad_interval
//
//  One sample per cycle unless the output stalls; pipeline stages: multiply,
//  divider load, 41 divider steps, terms, tangents, coefficients, three Horner
//  steps, saturation. The four ratio dividers retire one quotient bit per stage.
//  rst_n clears only the stage valid bits; payload registers are not reset.
//  A stalled output freezes the whole pipeline; in_ch.ready follows it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nonuniform_catmull_rom_segment (
  input  wire logic       clk,
  input  wire logic       rst_n,
  ncrs_in_if.sink         in_ch,
  ncrs_out_if.source      out_ch
);

  localparam int NSTEP = ncrs_pkg::QUO_W;
  localparam int ACC_W = ncrs_pkg::ACC_W;

  // floor((x*s + 2^15) / 2^16)
  function automatic logic signed [ACC_W-1:0] mul_s(
    input logic signed [ACC_W-1:0]   x,
    input logic [ncrs_pkg::PS_W-1:0] s
  );
    logic signed [ACC_W+ncrs_pkg::PS_W:0] p;
    p = x * $signed({1'b0, s});
    p = p + (ACC_W+ncrs_pkg::PS_W+1)'(33'sd32768);
    return ACC_W'(p >>> ncrs_pkg::S_FRAC);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_tan(
    input logic signed [ACC_W-1:0] x
  );
    logic signed [ACC_W-1:0] r;
    r = x;
    if (x > ncrs_pkg::TAN_LIM) r = ncrs_pkg::TAN_LIM;
    if (x < -ncrs_pkg::TAN_LIM) r = -ncrs_pkg::TAN_LIM;
    return r;
  endfunction

  function automatic logic signed [ncrs_pkg::PT_W-1:0] sat32(
    input logic signed [ACC_W-1:0] x
  );
    logic signed [ncrs_pkg::PT_W-1:0] r;
    r = ncrs_pkg::PT_W'(x);
    if (x > ncrs_pkg::POS_MAX) r = 32'sh7FFF_FFFF;
    if (x < ncrs_pkg::NEG_MIN) r = 32'sh8000_0000;
    return r;
  endfunction

  // Global advance: the pipeline moves unless a result is held
  logic adv;
  logic out_v_r;
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic in_xfer;
  assign in_xfer = in_ch.valid && adv;

  // ---------------------------------------------------------------- stage M
  ncrs_pkg::mul_lane_t mul_nxt [ncrs_pkg::NLANE];
  ncrs_pkg::mul_lane_t mul_r   [ncrs_pkg::NLANE];
  ncrs_pkg::side_t     sdm_nxt, sdm_r;
  logic                vm_r;

  // Form the four differences, magnitudes, products and divisors
  always_comb begin
    logic signed [ncrs_pkg::PT_W:0] dif [ncrs_pkg::NLANE];
    logic [ncrs_pkg::PT_W:0]        mag;
    logic [ncrs_pkg::IV_W-1:0]      dt0, dt1, dt2;
    dt0 = in_ch.interval_first;
    dt1 = in_ch.interval_middle;
    dt2 = in_ch.interval_last;
    dif[0] = 33'(in_ch.point_b) - 33'(in_ch.point_a);
    dif[1] = 33'(in_ch.point_c) - 33'(in_ch.point_a);
    dif[2] = 33'(in_ch.point_d) - 33'(in_ch.point_b);
    dif[3] = 33'(in_ch.point_d) - 33'(in_ch.point_c);
    mul_nxt[0].dvs = 32'(dt0);
    mul_nxt[1].dvs = 32'(dt0) + 32'(dt1);
    mul_nxt[2].dvs = 32'(dt1) + 32'(dt2);
    mul_nxt[3].dvs = 32'(dt2);
    for (int i = 0; i < ncrs_pkg::NLANE; i++) begin
      mag = dif[i][ncrs_pkg::PT_W] ? 33'(-dif[i]) : 33'(dif[i]);
      mul_nxt[i].neg  = dif[i][ncrs_pkg::PT_W];
      mul_nxt[i].prod = 64'(mag) * 64'(dt1);
    end
    sdm_nxt.pb  = in_ch.point_b;
    sdm_nxt.pc  = in_ch.point_c;
    sdm_nxt.s   = (in_ch.param_s > ncrs_pkg::S_ONE) ? ncrs_pkg::S_ONE : in_ch.param_s;
    sdm_nxt.bad = (dt0 == '0) || (dt1 == '0) || (dt2 == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_r <= mul_nxt;
      sdm_r <= sdm_nxt;
    end
  end

  // ---------------------------------------------------------- divider pipe
  ncrs_pkg::div_lane_t dv_r  [0:NSTEP][ncrs_pkg::NLANE];
  ncrs_pkg::side_t     sd_r  [0:NSTEP];
  logic                vd_r  [0:NSTEP];
  ncrs_pkg::div_lane_t dv0_nxt [ncrs_pkg::NLANE];

  // Load the high product bits as first remainder, flag quotients >= 2^41
  always_comb begin
    for (int i = 0; i < ncrs_pkg::NLANE; i++) begin
      dv0_nxt[i].rem = 32'(mul_r[i].prod[ncrs_pkg::PRD_W-1:NSTEP]);
      dv0_nxt[i].low = mul_r[i].prod[NSTEP-1:0];
      dv0_nxt[i].quo = '0;
      dv0_nxt[i].dvs = mul_r[i].dvs;
      dv0_nxt[i].neg = mul_r[i].neg;
      dv0_nxt[i].ovf = 32'(mul_r[i].prod[ncrs_pkg::PRD_W-1:NSTEP]) >= mul_r[i].dvs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= dv0_nxt;
      sd_r[0] <= sdm_r;
    end
  end

  // One restoring step per stage
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    ncrs_pkg::div_lane_t stp_nxt [ncrs_pkg::NLANE];

    always_comb begin
      logic [ncrs_pkg::DVS_W:0] r2;
      logic                     ge;
      for (int i = 0; i < ncrs_pkg::NLANE; i++) begin
        r2 = {dv_r[k][i].rem, dv_r[k][i].low[NSTEP-1]};
        ge = r2 >= {1'b0, dv_r[k][i].dvs};
        stp_nxt[i]     = dv_r[k][i];
        stp_nxt[i].rem = ge ? 32'(r2 - {1'b0, dv_r[k][i].dvs}) : r2[ncrs_pkg::DVS_W-1:0];
        stp_nxt[i].quo = {dv_r[k][i].quo[NSTEP-2:0], ge};
        stp_nxt[i].low = {dv_r[k][i].low[NSTEP-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= stp_nxt;
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  // ------------------------------------------------------------ term stage
  logic signed [ncrs_pkg::TRM_W-1:0] trm_nxt [ncrs_pkg::NLANE];
  logic signed [ncrs_pkg::TRM_W-1:0] trm_r   [ncrs_pkg::NLANE];
  ncrs_pkg::side_t                   sdt_r;
  logic                              vt_r;

  // Saturate each quotient to 2^40 and restore its sign
  always_comb begin
    logic [NSTEP-1:0] qs;
    for (int i = 0; i < ncrs_pkg::NLANE; i++) begin
      qs = (dv_r[NSTEP][i].ovf || dv_r[NSTEP][i].quo > ncrs_pkg::QUO_LIM) ?
           ncrs_pkg::QUO_LIM : dv_r[NSTEP][i].quo;
      trm_nxt[i] = dv_r[NSTEP][i].neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trm_r <= trm_nxt;
      sdt_r <= sd_r[NSTEP];
    end
  end

  // --------------------------------------------------------- tangent stage
  logic signed [ACC_W-1:0] m1_nxt, m2_nxt, m1_r, m2_r, cb_r;
  logic signed [ACC_W-1:0] cb;
  ncrs_pkg::side_t         sdg_r;
  logic                    vg_r;

  assign cb     = ACC_W'(sdt_r.pc) - ACC_W'(sdt_r.pb);
  assign m1_nxt = sat_tan(ACC_W'(trm_r[0]) - ACC_W'(trm_r[1]) + cb);
  assign m2_nxt = sat_tan(cb - ACC_W'(trm_r[2]) + ACC_W'(trm_r[3]));

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r  <= m1_nxt;
      m2_r  <= m2_nxt;
      cb_r  <= cb;
      sdg_r <= sdt_r;
    end
  end

  // ----------------------------------------------------- coefficient stage
  logic signed [ACC_W-1:0] k2x2_nxt, k3_nxt, k3x3_nxt;
  logic signed [ACC_W-1:0] k2_r, k2x2_r, k3_r, k3x3_r, m1k_r;
  ncrs_pkg::side_t         sdk_r;
  logic                    vk_r;
  logic signed [ACC_W-1:0] k2_nxt;

  // c2 = 3(c-b) - 2m1 - m2, c3 = 2(b-c) + m1 + m2, with their multiples
  assign k2_nxt   = 3 * cb_r - 2 * m1_r - m2_r;
  assign k2x2_nxt = 6 * cb_r - 4 * m1_r - 2 * m2_r;
  assign k3_nxt   = m1_r + m2_r - 2 * cb_r;
  assign k3x3_nxt = 3 * m1_r + 3 * m2_r - 6 * cb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      k2_r   <= k2_nxt;
      k2x2_r <= k2x2_nxt;
      k3_r   <= k3_nxt;
      k3x3_r <= k3x3_nxt;
      m1k_r  <= m1_r;
      sdk_r  <= sdg_r;
    end
  end

  // --------------------------------------------------------- Horner step 1
  logic signed [ACC_W-1:0] h1_r, t1_r, m1h_r;
  ncrs_pkg::side_t         sdh1_r;
  logic                    vh1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      h1_r   <= mul_s(k3_r, sdk_r.s) + k2_r;
      t1_r   <= mul_s(k3x3_r, sdk_r.s) + k2x2_r;
      m1h_r  <= m1k_r;
      sdh1_r <= sdk_r;
    end
  end

  // --------------------------------------------------------- Horner step 2
  logic signed [ACC_W-1:0] h2_r, t2_r;
  ncrs_pkg::side_t         sdh2_r;
  logic                    vh2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      h2_r   <= mul_s(h1_r, sdh1_r.s) + m1h_r;
      t2_r   <= mul_s(t1_r, sdh1_r.s) + m1h_r;
      sdh2_r <= sdh1_r;
    end
  end

  // --------------------------------------------------------- Horner step 3
  logic signed [ACC_W-1:0] p3_r, t3_r;
  logic                    bad3_r;
  logic                    vp3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r   <= mul_s(h2_r, sdh2_r.s) + ACC_W'(sdh2_r.pb);
      t3_r   <= t2_r;
      bad3_r <= sdh2_r.bad;
    end
  end

  // ------------------------------------------------------ output register
  logic signed [ncrs_pkg::PT_W-1:0] pos_r, tan_r;
  logic                             bad_r;

  // Saturate, and zero both results on a bad interval
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r <= bad3_r ? '0 : sat32(p3_r);
      tan_r <= bad3_r ? '0 : sat32(t3_r);
      bad_r <= bad3_r;
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r    <= 1'b0;
      vd_r    <= '{default: 1'b0};
      vt_r    <= 1'b0;
      vg_r    <= 1'b0;
      vk_r    <= 1'b0;
      vh1_r   <= 1'b0;
      vh2_r   <= 1'b0;
      vp3_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      vm_r    <= in_xfer;
      vd_r[0] <= vm_r;
      for (int k = 0; k < NSTEP; k++) vd_r[k+1] <= vd_r[k];
      vt_r    <= vd_r[NSTEP];
      vg_r    <= vt_r;
      vk_r    <= vg_r;
      vh1_r   <= vk_r;
      vh2_r   <= vh1_r;
      vp3_r   <= vh2_r;
      out_v_r <= vp3_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.position     = pos_r;
  assign out_ch.tangent      = tan_r;
  assign out_ch.bad_interval = bad_r;

endmodule

`default_nettype wire

### rtl/ncrs_checker.sv
// ---------------------------------------------------------------------------
// ncrs_checker
// Port-level checks of the segment evaluator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ncrs_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [ncrs_pkg::PT_W-1:0] position,
  input wire logic signed [ncrs_pkg::PT_W-1:0] tangent,
  input wire logic                           bad_interval
);

  // Held result stays put
  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(position) && $stable(tangent) && $stable(bad_interval))

  // Bad interval gives zero results
  `AST_IMPL(a_bad_zero, clk, rst_n, out_valid && bad_interval, position == 0 && tangent == 0)

  // Input opens whenever the output slot can move
  `AST_IMPL(a_in_open, clk, rst_n, !out_valid || out_ready, in_ready)

  // Input closes while a result is held
  `AST_IMPL(a_in_shut, clk, rst_n, out_valid && !out_ready, !in_ready && (in_valid || !in_valid))

endmodule

bind nonuniform_catmull_rom_segment ncrs_checker u_ncrs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .position     (out_ch.position),
  .tangent      (out_ch.tangent),
  .bad_interval (out_ch.bad_interval)
);

`default_nettype wire
